// ===== design/assert_macros.svh =====
// Assertion macros used by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== design/scc_pkg.sv =====
// Types and constants of the strongly connected components block.
`default_nettype none
package scc_pkg;
    localparam int NODE_W = 5;
    localparam int COMP_W = 5;

    typedef logic [NODE_W-1:0] node_t;

    localparam logic [1:0] FUNC_NODE = 2'd0;
    localparam logic [1:0] FUNC_EDGE = 2'd1;
    localparam logic [1:0] FUNC_RUN  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        node_t      src_node;
        node_t      dst_node;
    } in_word_t;

    typedef struct packed {
        node_t             node_id;
        logic [COMP_W-1:0] component_index;
        logic              last_of_component;
        logic              last_of_run;
        logic              status;
    } out_word_t;

    typedef struct packed {
        logic node_add;
        logic load_read;
        logic load_write;
        logic run_clear;
        logic root_step;
        logic enter_read;
        logic enter_root;
        logic enter_push;
        logic edge_take;
        logic low_from_disc;
        logic pop_emit;
        logic ret_pop;
        logic ret_merge;
        logic flush;
        logic full_emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] item_func;
        logic       node_ok;
        logic       edge_ok;
        logic       store_full;
        logic       scan_end;
        logic       root_take;
        logic       edge_more;
        logic       w_new;
        logic       w_onstack;
        logic       comp_root;
        logic       pop_match;
        logic       depth_one;
        logic       hold_valid;
        logic       out_free;
        logic       emit_ok;
    } status_t;
endpackage
`default_nettype wire

// ===== design/scc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== design/scc_ctrl.sv =====
// Sequencer for graph load and the depth-first component search.
`default_nettype none
module scc_ctrl import scc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LOAD_WR  = 4'd1;
    localparam logic [3:0] ST_FULL_OUT = 4'd2;
    localparam logic [3:0] ST_SCAN     = 4'd3;
    localparam logic [3:0] ST_ENTER    = 4'd4;
    localparam logic [3:0] ST_STEP     = 4'd5;
    localparam logic [3:0] ST_EDGE     = 4'd6;
    localparam logic [3:0] ST_LOW      = 4'd7;
    localparam logic [3:0] ST_POP_A    = 4'd8;
    localparam logic [3:0] ST_POP_B    = 4'd9;
    localparam logic [3:0] ST_RET_A    = 4'd10;
    localparam logic [3:0] ST_RET_B    = 4'd11;
    localparam logic [3:0] ST_FLUSH    = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (status.item_func)
                        FUNC_NODE: begin
                            cmd.node_add = status.node_ok;
                        end
                        FUNC_EDGE: begin
                            if (status.edge_ok) begin
                                if (status.store_full) begin
                                    state_next = ST_FULL_OUT;
                                end else begin
                                    cmd.load_read = 1'b1;
                                    state_next    = ST_LOAD_WR;
                                end
                            end
                        end
                        FUNC_RUN: begin
                            cmd.run_clear = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD_WR: begin
                cmd.load_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_FULL_OUT: begin
                if (status.out_free) begin
                    cmd.full_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (status.scan_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.root_step = 1'b1;
                    if (status.root_take) begin
                        cmd.enter_read = 1'b1;
                        cmd.enter_root = 1'b1;
                        state_next     = ST_ENTER;
                    end
                end
            end
            ST_ENTER: begin
                cmd.enter_push = 1'b1;
                state_next     = ST_STEP;
            end
            ST_STEP: begin
                priority if (status.edge_more) begin
                    state_next = ST_EDGE;
                end else if (status.comp_root) begin
                    state_next = ST_POP_A;
                end else begin
                    state_next = ST_RET_A;
                end
            end
            ST_EDGE: begin
                cmd.edge_take = 1'b1;
                priority if (status.w_new) begin
                    cmd.enter_read = 1'b1;
                    state_next     = ST_ENTER;
                end else if (status.w_onstack) begin
                    state_next = ST_LOW;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_LOW: begin
                cmd.low_from_disc = 1'b1;
                state_next        = ST_STEP;
            end
            ST_POP_A: begin
                state_next = ST_POP_B;
            end
            ST_POP_B: begin
                if (status.emit_ok) begin
                    cmd.pop_emit = 1'b1;
                    state_next   = status.pop_match ? ST_RET_A : ST_POP_A;
                end
            end
            ST_RET_A: begin
                cmd.ret_pop = 1'b1;
                state_next  = status.depth_one ? ST_SCAN : ST_RET_B;
            end
            ST_RET_B: begin
                cmd.ret_merge = 1'b1;
                state_next    = ST_STEP;
            end
            ST_FLUSH: begin
                priority if (!status.hold_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/scc_dp.sv =====
// Graph stores, search stacks, counters and output staging.
`default_nettype none
module scc_dp import scc_pkg::*; #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_word,
    input  logic      m_ready,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      m_valid,
    output out_word_t m_word
);
    localparam int NAW  = $clog2(MAX_NODES);
    localparam int TW   = $clog2(MAX_NODES + 1);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int EW   = $clog2(MAX_EDGES + 1);
    localparam int NE_W = 2 * EAW;
    localparam int FR_W = NODE_W + EW + EAW + 2 * TW;
    localparam logic [EW-1:0] EDGE_EMPTY = EW'(MAX_EDGES);

    logic [MAX_NODES-1:0] present_reg, present_next;
    logic [MAX_NODES-1:0] has_edge_reg, has_edge_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [MAX_NODES-1:0] onstack_reg, onstack_next;
    logic [EW-1:0]        edges_reg, edges_next;
    logic [TW-1:0]        root_reg, root_next;
    logic [TW-1:0]        clk_reg, clk_next;
    logic [TW-1:0]        msd_reg, msd_next;
    logic [TW-1:0]        depth_reg, depth_next;
    logic [COMP_W-1:0]    comp_reg, comp_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 out_valid_reg, out_valid_next;

    node_t                src_reg, src_next;
    node_t                dst_reg, dst_next;
    node_t                x_reg, x_next;
    node_t                top_node_reg, top_node_next;
    logic [EW-1:0]        top_edge_reg, top_edge_next;
    logic [EAW-1:0]       top_last_reg, top_last_next;
    logic [TW-1:0]        top_low_reg, top_low_next;
    logic [TW-1:0]        top_disc_reg, top_disc_next;
    out_word_t            hold_word_reg, hold_word_next;
    out_word_t            out_word_reg, out_word_next;

    logic [NE_W-1:0]      ne_rdata;
    logic [NE_W-1:0]      ne_wdata;
    logic [NAW-1:0]       ne_raddr;
    logic [EAW-1:0]       ne_first, ne_last;
    node_t                edge_rdata;
    logic [EAW-1:0]       link_rdata;
    logic [TW-1:0]        disc_rdata;
    node_t                ms_rdata;
    logic [FR_W-1:0]      fr_rdata;
    logic [FR_W-1:0]      fr_wdata;
    node_t                enter_node;
    logic [EAW-1:0]       new_edge;
    logic                 src_has;
    logic                 out_free;
    out_word_t            pop_word;
    node_t                fr_node;
    logic [EW-1:0]        fr_edge;
    logic [EAW-1:0]       fr_last;
    logic [TW-1:0]        fr_low;
    logic [TW-1:0]        fr_disc;

    assign ne_first   = ne_rdata[NE_W-1:EAW];
    assign ne_last    = ne_rdata[EAW-1:0];
    assign new_edge   = edges_reg[EAW-1:0];
    assign src_has    = has_edge_reg[NAW'(src_reg)];
    assign ne_wdata   = src_has ? {ne_first, new_edge} : {new_edge, new_edge};
    assign enter_node = cmd.enter_root ? NODE_W'(root_reg) : edge_rdata;
    assign ne_raddr   = cmd.enter_read ? NAW'(enter_node) : NAW'(s_word.src_node);
    assign fr_wdata   = {top_node_reg, top_edge_reg, top_last_reg, top_low_reg, top_disc_reg};
    assign fr_node    = fr_rdata[FR_W-1 -: NODE_W];
    assign fr_edge    = fr_rdata[FR_W-NODE_W-1 -: EW];
    assign fr_last    = fr_rdata[2*TW+EAW-1 -: EAW];
    assign fr_low     = fr_rdata[2*TW-1 -: TW];
    assign fr_disc    = fr_rdata[TW-1:0];
    assign out_free   = !out_valid_reg || m_ready;

    scc_ram #(.WIDTH(NE_W), .DEPTH(MAX_NODES)) u_node_edge_ram (
        .aclk(aclk), .we(cmd.load_write), .waddr(NAW'(src_reg)), .wdata(ne_wdata),
        .raddr(ne_raddr), .rdata(ne_rdata)
    );

    scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_target_ram (
        .aclk(aclk), .we(cmd.load_write), .waddr(new_edge), .wdata(dst_reg),
        .raddr(top_edge_reg[EAW-1:0]), .rdata(edge_rdata)
    );

    scc_ram #(.WIDTH(EAW), .DEPTH(MAX_EDGES)) u_edge_link_ram (
        .aclk(aclk), .we(cmd.load_write && src_has), .waddr(ne_last), .wdata(new_edge),
        .raddr(top_edge_reg[EAW-1:0]), .rdata(link_rdata)
    );

    scc_ram #(.WIDTH(TW), .DEPTH(MAX_NODES)) u_disc_ram (
        .aclk(aclk), .we(cmd.enter_push), .waddr(NAW'(x_reg)), .wdata(clk_reg),
        .raddr(NAW'(edge_rdata)), .rdata(disc_rdata)
    );

    scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_member_stack_ram (
        .aclk(aclk), .we(cmd.enter_push), .waddr(NAW'(msd_reg)), .wdata(x_reg),
        .raddr(NAW'(msd_reg - TW'(1))), .rdata(ms_rdata)
    );

    scc_ram #(.WIDTH(FR_W), .DEPTH(MAX_NODES)) u_frame_ram (
        .aclk(aclk), .we(cmd.enter_push && (depth_reg != '0)),
        .waddr(NAW'(depth_reg - TW'(1))), .wdata(fr_wdata),
        .raddr(NAW'(depth_reg - TW'(2))), .rdata(fr_rdata)
    );

    always_comb begin
        pop_word                   = '0;
        pop_word.node_id           = ms_rdata;
        pop_word.component_index   = comp_reg;
        pop_word.last_of_component = (ms_rdata == top_node_reg);
    end

    always_comb begin
        status            = '0;
        status.item_func  = s_word.func;
        status.node_ok    = int'(s_word.src_node) < MAX_NODES;
        status.edge_ok    = (int'(s_word.src_node) < MAX_NODES)
                            && (int'(s_word.dst_node) < MAX_NODES);
        status.store_full = edges_reg == EDGE_EMPTY;
        status.scan_end   = root_reg == TW'(MAX_NODES);
        status.root_take  = present_reg[root_reg[NAW-1:0]] && !visited_reg[root_reg[NAW-1:0]];
        status.edge_more  = top_edge_reg != EDGE_EMPTY;
        status.w_new      = !visited_reg[NAW'(edge_rdata)];
        status.w_onstack  = onstack_reg[NAW'(edge_rdata)];
        status.comp_root  = top_low_reg == top_disc_reg;
        status.pop_match  = ms_rdata == top_node_reg;
        status.depth_one  = depth_reg == TW'(1);
        status.hold_valid = hold_valid_reg;
        status.out_free   = out_free;
        status.emit_ok    = !hold_valid_reg || out_free;
    end

    always_comb begin
        present_next    = present_reg;
        has_edge_next   = has_edge_reg;
        visited_next    = visited_reg;
        onstack_next    = onstack_reg;
        edges_next      = edges_reg;
        root_next       = root_reg;
        clk_next        = clk_reg;
        msd_next        = msd_reg;
        depth_next      = depth_reg;
        comp_next       = comp_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        src_next        = src_reg;
        dst_next        = dst_reg;
        x_next          = x_reg;
        top_node_next   = top_node_reg;
        top_edge_next   = top_edge_reg;
        top_last_next   = top_last_reg;
        top_low_next    = top_low_reg;
        top_disc_next   = top_disc_reg;
        hold_word_next  = hold_word_reg;
        out_word_next   = out_word_reg;

        if (cmd.node_add) begin
            present_next[NAW'(s_word.src_node)] = 1'b1;
        end
        if (cmd.load_read) begin
            src_next = s_word.src_node;
            dst_next = s_word.dst_node;
        end
        if (cmd.load_write) begin
            edges_next                  = edges_reg + EW'(1);
            has_edge_next[NAW'(src_reg)] = 1'b1;
            present_next[NAW'(src_reg)]  = 1'b1;
            present_next[NAW'(dst_reg)]  = 1'b1;
        end
        if (cmd.run_clear) begin
            visited_next = '0;
            onstack_next = '0;
            root_next    = '0;
            clk_next     = '0;
            msd_next     = '0;
            depth_next   = '0;
            comp_next    = '0;
        end
        if (cmd.root_step) begin
            root_next = root_reg + TW'(1);
        end
        if (cmd.enter_read) begin
            x_next = enter_node;
        end
        if (cmd.edge_take) begin
            top_edge_next = (top_edge_reg[EAW-1:0] == top_last_reg) ? EDGE_EMPTY
                                                                     : EW'(link_rdata);
        end
        if (cmd.enter_push) begin
            visited_next[NAW'(x_reg)] = 1'b1;
            onstack_next[NAW'(x_reg)] = 1'b1;
            clk_next      = clk_reg + TW'(1);
            msd_next      = msd_reg + TW'(1);
            depth_next    = depth_reg + TW'(1);
            top_node_next = x_reg;
            top_edge_next = has_edge_reg[NAW'(x_reg)] ? EW'(ne_first) : EDGE_EMPTY;
            top_last_next = ne_last;
            top_low_next  = clk_reg;
            top_disc_next = clk_reg;
        end
        if (cmd.low_from_disc && (disc_rdata < top_low_reg)) begin
            top_low_next = disc_rdata;
        end
        if (cmd.pop_emit) begin
            msd_next                    = msd_reg - TW'(1);
            onstack_next[NAW'(ms_rdata)] = 1'b0;
            if (status.pop_match) begin
                comp_next = comp_reg + COMP_W'(1);
            end
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_word_next  = hold_word_reg;
            end
            hold_valid_next = 1'b1;
            hold_word_next  = pop_word;
        end
        if (cmd.ret_pop) begin
            depth_next = depth_reg - TW'(1);
        end
        if (cmd.ret_merge) begin
            top_node_next = fr_node;
            top_edge_next = fr_edge;
            top_last_next = fr_last;
            top_disc_next = fr_disc;
            top_low_next  = (top_low_reg < fr_low) ? top_low_reg : fr_low;
        end
        if (cmd.flush) begin
            out_valid_next            = 1'b1;
            out_word_next             = hold_word_reg;
            out_word_next.last_of_run = 1'b1;
            hold_valid_next           = 1'b0;
        end
        if (cmd.full_emit) begin
            out_valid_next       = 1'b1;
            out_word_next        = '0;
            out_word_next.status = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg    <= '0;
            has_edge_reg   <= '0;
            visited_reg    <= '0;
            onstack_reg    <= '0;
            edges_reg      <= '0;
            root_reg       <= '0;
            clk_reg        <= '0;
            msd_reg        <= '0;
            depth_reg      <= '0;
            comp_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            present_reg    <= present_next;
            has_edge_reg   <= has_edge_next;
            visited_reg    <= visited_next;
            onstack_reg    <= onstack_next;
            edges_reg      <= edges_next;
            root_reg       <= root_next;
            clk_reg        <= clk_next;
            msd_reg        <= msd_next;
            depth_reg      <= depth_next;
            comp_reg       <= comp_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        x_reg         <= x_next;
        top_node_reg  <= top_node_next;
        top_edge_reg  <= top_edge_next;
        top_last_reg  <= top_last_next;
        top_low_reg   <= top_low_next;
        top_disc_reg  <= top_disc_next;
        hold_word_reg <= hold_word_next;
        out_word_reg  <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;
endmodule
`default_nettype wire

// ===== design/strongly_connected_components_top.sv =====
// Top level of the Tarjan strongly connected components block.
//
//   channel  ports                       word
//   input    s_valid s_ready s_word      func, src_node, dst_node
//   result   m_valid m_ready m_word      node_id, component_index, flags, status
//
// A node item marks its node present; an edge item is latched, then written to the stores;
// a full edge store answers with one status word. A run scans roots, enters a node, follows
// an edge via the step and edge states (plus a low update if its target is on the stack),
// pops members via the pop states and returns via the return states (from a root only the first).
// Reset clears node presence, edge count and all control; the RAMs hold no reset state.
// A stalled result channel holds the run at its next pop; the last word leaves at run end.
`default_nettype none
`include "assert_macros.svh"
module strongly_connected_components_top import scc_pkg::*; #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);
    cmd_t    cmd;
    status_t status;

    scc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    scc_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_word  (m_word)
    );

    `ASSERT_NEVER(a_emit_overlap, aclk, aresetn, cmd.pop_emit && cmd.full_emit)
    `ASSERT_PROP(a_flush_empties, aclk, aresetn, cmd.flush |=> !status.hold_valid)
    `ASSERT_PROP(a_idle_no_hold, aclk, aresetn, s_ready |-> !status.hold_valid)
    `ASSERT_PROP(a_full_room, aclk, aresetn, cmd.full_emit |-> status.out_free)
endmodule
`default_nettype wire

// ===== tb/strongly_connected_components_top_tb.sv =====
// Testbench of the strongly connected components block: random graphs, runs, scoreboard check.
`default_nettype none
module strongly_connected_components_top_tb;
    import scc_pkg::*;

    localparam int NODES = 32;
    localparam int EDGES = 256;
    localparam int CYCLE_LIMIT = 2000000;

    class scc_scoreboard;
        bit        present[NODES];
        bit [4:0]  target[EDGES];
        int        next_link[EDGES];
        int        first_edge[NODES];
        int        last_edge[NODES];
        int        stored;
        out_word_t pending[$];
        int        errors;

        function new();
            foreach (present[i]) begin
                present[i] = 1'b0;
                first_edge[i] = EDGES;
                last_edge[i] = 0;
            end
            stored = 0;
            errors = 0;
        endfunction

        function void add_member(int node, int comp, bit last_comp);
            out_word_t w;
            w.node_id = node[4:0];
            w.component_index = comp[4:0];
            w.last_of_component = last_comp;
            w.last_of_run = 1'b0;
            w.status = 1'b0;
            pending = {pending, w};
        endfunction

        function void find_components();
            bit       seen[NODES];
            bit       stacked[NODES];
            int       disc[NODES];
            int       low[NODES];
            int       members[$];
            int       frame_node[$];
            int       frame_edge[$];
            int       clk_count;
            int       comp;
            int       emitted;
            int       v;
            int       e;
            int       w;
            int       p;
            foreach (seen[i]) begin
                seen[i] = 1'b0;
                stacked[i] = 1'b0;
            end
            clk_count = 0;
            comp = 0;
            emitted = 0;
            for (int r = 0; r < NODES; r++) begin
                if (!present[r] || seen[r]) continue;
                seen[r] = 1'b1; disc[r] = clk_count; low[r] = clk_count; clk_count++;
                members = {members, r}; stacked[r] = 1'b1;
                frame_node = {frame_node, r}; frame_edge = {frame_edge, first_edge[r]};
                while (frame_node.size() > 0) begin
                    v = frame_node[$];
                    e = frame_edge[$];
                    if (e < EDGES) begin
                        w = int'(target[e]);
                        frame_edge[frame_edge.size()-1] = next_link[e];
                        if (!seen[w]) begin
                            seen[w] = 1'b1; disc[w] = clk_count; low[w] = clk_count;
                            clk_count++;
                            members = {members, w}; stacked[w] = 1'b1;
                            frame_node = {frame_node, w};
                            frame_edge = {frame_edge, first_edge[w]};
                        end else if (stacked[w] && disc[w] < low[v]) begin
                            low[v] = disc[w];
                        end
                        continue;
                    end
                    if (low[v] == disc[v]) begin
                        do begin
                            w = members.pop_back();
                            stacked[w] = 1'b0;
                            add_member(w, comp, w == v);
                            emitted++;
                        end while (w != v);
                        comp++;
                    end
                    void'(frame_node.pop_back());
                    void'(frame_edge.pop_back());
                    if (frame_node.size() > 0) begin
                        p = frame_node[$];
                        if (low[v] < low[p]) low[p] = low[v];
                    end
                end
            end
            if (emitted > 0) pending[pending.size()-1].last_of_run = 1'b1;
        endfunction

        function void note_input(in_word_t in);
            out_word_t w;
            int s;
            int d;
            s = int'(in.src_node);
            d = int'(in.dst_node);
            case (in.func)
                FUNC_NODE: begin
                    present[s] = 1'b1;
                end
                FUNC_EDGE: begin
                    if (stored >= EDGES) begin
                        w = '0;
                        w.status = 1'b1;
                        pending = {pending, w};
                    end else begin
                        target[stored] = d[4:0];
                        next_link[stored] = EDGES;
                        if (first_edge[s] >= EDGES) first_edge[s] = stored;
                        else next_link[last_edge[s]] = stored;
                        last_edge[s] = stored;
                        stored++;
                        present[s] = 1'b1;
                        present[d] = 1'b1;
                    end
                end
                FUNC_RUN: begin
                    find_components();
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w) begin
                $display("%0t: mismatch, expected %p, actual %p", $time, exp_w, got);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    scc_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  cycles;

    strongly_connected_components_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;
        m_ready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 75;
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // check results and randomize the receiver's ready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_result(m_word);
            m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(logic [1:0] func, int src, int dst);
        in_word_t w;
        w.func = func;
        w.src_node = src[4:0];
        w.dst_node = dst[4:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic random_graph(int n_nodes, int n_edges);
        int base;
        base = $urandom_range(NODES - n_nodes);
        for (int i = 0; i < n_edges; i++) begin
            if ($urandom_range(9) == 0)
                send_word(FUNC_NODE, base + $urandom_range(n_nodes - 1), $urandom);
            else
                send_word(FUNC_EDGE, base + $urandom_range(n_nodes - 1),
                          base + $urandom_range(n_nodes - 1));
        end
        send_word(FUNC_RUN, $urandom, $urandom);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty run, noise, extremes, a cycle and a self loop
        send_word(FUNC_RUN, 0, 0);
        send_word(2'd3, 31, 31);
        send_word(FUNC_NODE, 31, 0);
        send_word(FUNC_NODE, 0, 31);
        send_word(FUNC_EDGE, 1, 2);
        send_word(FUNC_EDGE, 2, 3);
        send_word(FUNC_EDGE, 3, 1);
        send_word(FUNC_EDGE, 3, 4);
        send_word(FUNC_EDGE, 5, 5);
        send_word(FUNC_EDGE, 30, 31);
        send_word(FUNC_EDGE, 31, 30);
        send_word(FUNC_EDGE, 21, 10);
        send_word(FUNC_RUN, 31, 31);
        send_word(FUNC_RUN, 10, 21);
        drain();

        // hold the receiver off while a run fills the block
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                send_word(FUNC_RUN, 0, 0);
                for (int i = 0; i < 20; i++) send_word(FUNC_NODE, i, 0);
                send_word(FUNC_RUN, 0, 0);
            end
        join
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 24 : 0;
            for (int g = 0; g < 15; g++) begin
                random_graph(2 + $urandom_range(10), 1 + $urandom_range(14));
            end
            drain();
        end

        // fill the edge store, then try more edges
        send_idle_pct = 5;
        recv_idle_pct = 10;
        while (board.stored < EDGES) send_word(FUNC_EDGE, $urandom, $urandom);
        for (int i = 0; i < 6; i++) send_word(FUNC_EDGE, $urandom, $urandom);
        send_word(FUNC_RUN, 0, 0);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
